### hw/rtl/ftprp_pkg.sv
// shared types, character codes and helpers for the ftp reply parser
// no dependencies
`default_nettype none

package ftprp_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int REPLY_LEN_W     = 16;
    localparam int CODE_W          = 10;
    localparam int STATUS_W        = 2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [4:0] {
        PH_CODE   = 5'b00001,
        PH_SEP    = 5'b00010,
        PH_BODY   = 5'b00100,
        PH_LF     = 5'b01000,
        PH_LSTART = 5'b10000
    } t_phase;

    typedef logic [2:0][3:0] t_digits;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  dpos;
        t_digits     digits;
        logic        multi;
        logic        match;
        logic        term;
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [CODE_W-1:0]      code;
        logic                   multi;
        logic [REPLY_LEN_W-1:0] length;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:  PH_CODE,
        dpos:   2'd0,
        digits: '0,
        multi:  1'b0,
        match:  1'b0,
        term:   1'b0
    };

    // digit i of the code, position 0 is the hundreds digit
    function automatic logic [3:0] digit_at(input t_digits d, input logic [1:0] pos);
        logic [3:0] v;
        case (pos)
            2'd0:    v = d[0];
            2'd1:    v = d[1];
            default: v = d[2];
        endcase
        return v;
    endfunction

    // 100*d0 + 10*d1 + d2 with shifts and adds
    function automatic logic [CODE_W-1:0] code_of(input t_digits d);
        logic [CODE_W-1:0] h;
        logic [CODE_W-1:0] t;
        logic [CODE_W-1:0] u;
        h = {d[0], 6'b0} + {1'b0, d[0], 5'b0} + {4'b0, d[0], 2'b0};
        t = {3'b0, d[1], 3'b0} + {5'b0, d[1], 1'b0};
        u = {6'b0, d[2]};
        return h + t + u;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ftprp_if.sv
// valid/ready channel interfaces for received bytes and parse results
// depends on ftprp_pkg
`default_nettype none

interface ftprp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ftprp_res_if;
    logic                             valid;
    logic                             ready;
    logic [ftprp_pkg::STATUS_W-1:0]    status;
    logic [ftprp_pkg::CODE_W-1:0]      reply_code;
    logic                             is_multiline;
    logic [ftprp_pkg::REPLY_LEN_W-1:0] reply_length;

    modport source (output valid, output status, output reply_code,
                    output is_multiline, output reply_length, input ready);
    modport sink   (input valid, input status, input reply_code,
                    input is_multiline, input reply_length, output ready);
endinterface

`default_nettype wire

### hw/rtl/ftprp_step.sv
// next-state and result logic for one received byte
// depends on ftprp_pkg
`default_nettype none

module ftprp_step #(
    parameter int LENGTH_BITS = ftprp_pkg::LENGTH_BITS_DEF
) (
    input  wire ftprp_pkg::t_state  i_state,
    input  wire [((LENGTH_BITS < ftprp_pkg::REPLY_LEN_W) ? LENGTH_BITS
                  : ftprp_pkg::REPLY_LEN_W)-1:0] i_cnt,
    input  wire [7:0]                i_byte,
    output ftprp_pkg::t_state        o_state,
    output logic [((LENGTH_BITS < ftprp_pkg::REPLY_LEN_W) ? LENGTH_BITS
                   : ftprp_pkg::REPLY_LEN_W)-1:0] o_cnt,
    output ftprp_pkg::t_result       o_result
);
    import ftprp_pkg::*;

    localparam int CntW = (LENGTH_BITS < REPLY_LEN_W) ? LENGTH_BITS : REPLY_LEN_W;

    t_state             st;
    logic [CntW-1:0]    cnt_inc;
    logic [STATUS_W-1:0] status;
    logic [7:0]         lo;
    logic [7:0]         hi;

    // length saturates at all ones
    assign cnt_inc = (i_cnt == {CntW{1'b1}}) ? i_cnt : i_cnt + 1'b1;

    always_comb begin
        st     = i_state;
        status = ST_BUSY;
        lo     = (i_state.dpos == 2'd0) ? CH_ONE : CH_ZERO;
        hi     = (i_state.dpos == 2'd2 || i_state.dpos == 2'd3) ? CH_NINE : CH_FIVE;
        case (i_state.phase)
            PH_SEP: begin
                if (i_byte == CH_SPACE) begin
                    st.multi = 1'b0;
                    st.phase = PH_BODY;
                end else if (i_byte == CH_DASH) begin
                    st.multi = 1'b1;
                    st.phase = PH_BODY;
                end else begin
                    status = ST_BAD;
                end
            end
            PH_BODY: begin
                if (i_byte == CH_CR) begin
                    st.phase = PH_LF;
                end else if (i_byte == CH_LF) begin
                    status = ST_BAD;
                end
            end
            PH_LF: begin
                if (i_byte != CH_LF) begin
                    status = ST_BAD;
                end else if (!i_state.multi || i_state.term) begin
                    status = ST_DONE;
                end else begin
                    st.phase = PH_LSTART;
                    st.dpos  = 2'd0;
                    st.match = 1'b1;
                    st.term  = 1'b0;
                end
            end
            PH_LSTART: begin
                if (i_byte == CH_LF) begin
                    status = ST_BAD;
                end else if (i_byte == CH_CR) begin
                    st.phase = PH_LF;
                end else if (i_state.dpos != 2'd3) begin
                    // later line compared against the code one column at a time
                    if (i_byte != {4'h3, digit_at(i_state.digits, i_state.dpos)}) begin
                        st.match = 1'b0;
                    end
                    st.dpos = i_state.dpos + 2'd1;
                end else begin
                    if (i_state.match && i_byte == CH_SPACE) begin
                        st.term = 1'b1;
                    end
                    st.phase = PH_BODY;
                end
            end
            default: begin
                // code digits, also the recovery path for unused phase codes
                st.phase = PH_CODE;
                if (i_byte < lo || i_byte > hi) begin
                    status = ST_BAD;
                end else begin
                    case (i_state.dpos)
                        2'd0:    st.digits[0] = i_byte[3:0];
                        2'd1:    st.digits[1] = i_byte[3:0];
                        default: st.digits[2] = i_byte[3:0];
                    endcase
                    if (i_state.dpos == 2'd2 || i_state.dpos == 2'd3) begin
                        st.dpos  = 2'd0;
                        st.phase = PH_SEP;
                    end else begin
                        st.dpos = i_state.dpos + 2'd1;
                    end
                end
            end
        endcase
    end

    always_comb begin
        o_result        = '0;
        o_result.status = status;
        if (status == ST_DONE) begin
            o_result.code   = code_of(i_state.digits);
            o_result.multi  = i_state.multi;
            o_result.length = REPLY_LEN_W'(cnt_inc);
        end
        if (status == ST_BUSY) begin
            o_state = st;
            o_cnt   = cnt_inc;
        end else begin
            o_state = STATE_RESET;
            o_cnt   = '0;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ftp_reply_parser.sv
// top level of the ftp reply parser: parse state, result register, handshakes
// depends on ftprp_pkg, ftprp_if, ftprp_step
//
//   channel   | dir | payload                                        | handshake
//   i_rx      | in  | rx_byte[7:0]                                   | valid/ready
//   o_res     | out | status[1:0] reply_code[9:0] is_multiline       | valid/ready
//             |     | reply_length[15:0]                             |
//
// one result per byte, registered: result valid in the cycle after accept
// a byte can be accepted every cycle unless a result is stalled; the parse update sits between the
// state registers and the result register
// synchronous active-low reset returns to waiting for a first code digit
// a stalled result holds; input ready drops only while it is held
`default_nettype none

module ftp_reply_parser #(
    parameter int LENGTH_BITS = ftprp_pkg::LENGTH_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ftprp_rx_if.sink     i_rx,
    ftprp_res_if.source  o_res
);
    import ftprp_pkg::*;

    localparam int CntW = (LENGTH_BITS < REPLY_LEN_W) ? LENGTH_BITS : REPLY_LEN_W;

    t_state          r_state;
    t_state          n_state;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    t_result         r_out;
    t_result         n_out;
    logic            r_out_valid;
    logic            accept;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    ftprp_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .i_state  (r_state),
        .i_cnt    (r_cnt),
        .i_byte   (i_rx.rx_byte),
        .o_state  (n_state),
        .o_cnt    (n_cnt),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.reply_code   = r_out.code;
    assign o_res.is_multiline = r_out.multi;
    assign o_res.reply_length = r_out.length;

endmodule

`default_nettype wire

### hw/rtl/ftprp_checker.sv
// port-level checks on the ftp reply parser, bound to the top level
// depends on ftprp_pkg and ftp_reply_parser
`default_nettype none

module ftprp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [1:0]  i_status,
    input wire [9:0]  i_code,
    input wire        i_multi,
    input wire [15:0] i_length
);
    import ftprp_pkg::*;

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // fields other than status are zero unless a reply completed
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_DONE)
            |-> (i_code == '0 && !i_multi && i_length == '0))
        else $error("reply fields set on a non-complete transaction");

    // a completed reply carries a legal code
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_DONE)
            |-> (i_code >= 10'd100 && i_code <= 10'd559))
        else $error("completed reply code out of range");

    // shortest reply is three digits, separator and crlf
    a_min_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_DONE) |-> (i_length >= 16'd6))
        else $error("completed reply shorter than six bytes");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_status) && $stable(i_length)))
        else $error("stalled result changed");

endmodule

bind ftp_reply_parser ftprp_checker u_ftprp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_code      (o_res.reply_code),
    .i_multi     (o_res.is_multiline),
    .i_length    (o_res.reply_length)
);

`default_nettype wire
